// ===== rtl/ilt_pkg.sv =====
// Shared types and codes for the indexed list table.
// Used by ilt_cell and indexed_list_table_unit; depends on nothing.
`default_nettype none

package ilt_pkg;

    typedef enum logic [3:0] {
        MODE_APPEND     = 4'd0,
        MODE_INSERT     = 4'd1,
        MODE_REMOVE_AT  = 4'd2,
        MODE_REMOVE_VAL = 4'd3,
        MODE_READ       = 4'd4,
        MODE_FIRST      = 4'd5,
        MODE_LAST       = 4'd6,
        MODE_FIND_FIRST = 4'd7,
        MODE_FIND_LAST  = 4'd8,
        MODE_CLEAR      = 4'd9
    } mode_t;

    typedef enum logic [2:0] {
        STATUS_OK        = 3'd0,
        STATUS_RANGE     = 3'd1,
        STATUS_EMPTY     = 3'd2,
        STATUS_FULL      = 3'd3,
        STATUS_NOT_FOUND = 3'd4
    } status_t;

    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } state_t;

    // Shift command broadcast to every cell of the chain.
    typedef struct packed {
        logic ins;  // open a slot at pos, later entries move up
        logic rem;  // drop the entry at pos, later entries move down
    } cell_cmd_t;

    localparam int POS_PORT_W   = 7;
    localparam int VALUE_PORT_W = 32;

endpackage

`default_nettype wire

// ===== rtl/ilt_cell.sv =====
// One list entry of the chain: holds a value, shifts to or from its
// neighbors and compares against the search value. Depends on ilt_pkg.
`default_nettype none

module ilt_cell
    import ilt_pkg::*;
#(
    parameter int INDEX       = 0,
    parameter int POS_W       = 7,
    parameter int VALUE_WIDTH = 32
) (
    input  wire logic                   clk,
    input  wire cell_cmd_t              cmd,
    input  wire logic [POS_W-1:0]       pos,
    input  wire logic                   cmp_en,
    input  wire logic [VALUE_WIDTH-1:0] new_val,
    input  wire logic [VALUE_WIDTH-1:0] prev_val,
    input  wire logic [VALUE_WIDTH-1:0] next_val,
    output logic      [VALUE_WIDTH-1:0] entry,
    output logic                        match
);

    localparam logic [POS_W-1:0] MY_IDX = POS_W'(INDEX);

    logic [VALUE_WIDTH-1:0] entry_reg;
    logic [VALUE_WIDTH-1:0] entry_next;
    logic                   match_reg;

    always_comb
    begin
        entry_next = entry_reg;
        if (cmd.ins)
        begin
            if (MY_IDX == pos)
                entry_next = new_val;
            else if (MY_IDX > pos)
                entry_next = prev_val;
        end
        else if (cmd.rem)
        begin
            if (MY_IDX >= pos)
                entry_next = next_val;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
        if (cmp_en)
            match_reg <= (entry_reg == new_val);
    end

    assign entry = entry_reg;
    assign match = match_reg;

endmodule

`default_nettype wire

// ===== rtl/indexed_list_table_unit.sv =====
// Indexed list table: ordered list of up to CAPACITY values in a chain of cells.
// A request is accepted in ST_IDLE, where every cell compares the search value;
// the priority pick and the shift or read commit follow in ST_EXEC, which holds
// while the output stalls. The result registers at commit; new requests wait.
// Reset clears the count and the control state; entry contents stay undefined
// until written, with no clearing pass.
`default_nettype none

module indexed_list_table_unit
    import ilt_pkg::*;
#(
    parameter int CAPACITY    = 64,
    parameter int VALUE_WIDTH = 32
) (
    input  wire logic                    clk,
    input  wire logic                    rst_n,

    input  wire logic                    in_valid,
    output logic                         in_stall,
    input  wire logic [3:0]              mode,
    input  wire logic [POS_PORT_W-1:0]   position,
    input  wire logic [VALUE_PORT_W-1:0] item_value,
    input  wire logic                    clear_all,

    output logic                         out_valid,
    input  wire logic                    out_stall,
    output logic [2:0]                   status,
    output logic [VALUE_PORT_W-1:0]      read_value,
    output logic signed [POS_PORT_W-1:0] found_position,
    output logic [POS_PORT_W-1:0]        list_count
);

    localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int CMP_W = (CNT_W > POS_PORT_W) ? CNT_W : POS_PORT_W;
    localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

    state_t state_reg;
    state_t state_next;

    logic [CNT_W-1:0]       count_reg;
    logic [CNT_W-1:0]       count_next;
    logic [3:0]             mode_reg;
    logic [POS_PORT_W-1:0]  pos_reg;
    logic [VALUE_WIDTH-1:0] val_reg;
    logic                   clr_reg;

    logic                    out_valid_reg;
    logic                    out_valid_next;
    logic [2:0]              status_reg;
    logic [VALUE_PORT_W-1:0] read_value_reg;
    logic [POS_PORT_W-1:0]   found_reg;
    logic [POS_PORT_W-1:0]   list_count_reg;

    logic accept;
    logic commit;

    logic [VALUE_WIDTH-1:0] entries [CAPACITY];
    logic [CAPACITY-1:0]    match_vec;
    logic [CAPACITY-1:0]    hit_vec;
    logic [VALUE_WIDTH-1:0] new_val;

    cell_cmd_t        cmd;
    logic [CMP_W-1:0] cell_pos;
    logic [CMP_W-1:0] pos_c;
    logic [CMP_W-1:0] cnt_c;
    logic [IDX_W-1:0] first_idx;
    logic [IDX_W-1:0] last_idx;
    logic [IDX_W-1:0] rd_idx;
    logic             any_hit;
    logic             full;

    status_t                status_n;
    logic [VALUE_WIDTH-1:0] rd_n;
    logic [POS_PORT_W-1:0]  found_n;
    logic                   do_ins;
    logic                   do_rem;

    // The search value is broadcast at accept time, the new value at commit.
    assign new_val = accept ? VALUE_WIDTH'(item_value) : val_reg;

    genvar g;
    generate
        for (g = 0; g < CAPACITY; g++)
        begin : g_cell
            logic [VALUE_WIDTH-1:0] prev_v;
            logic [VALUE_WIDTH-1:0] next_v;

            if (g == 0)
            begin : g_head
                assign prev_v = entries[g];
            end
            else
            begin : g_prev
                assign prev_v = entries[g-1];
            end

            if (g == CAPACITY - 1)
            begin : g_tail
                assign next_v = entries[g];
            end
            else
            begin : g_next
                assign next_v = entries[g+1];
            end

            ilt_cell #(
                .INDEX       (g),
                .POS_W       (CMP_W),
                .VALUE_WIDTH (VALUE_WIDTH)
            ) u_cell (
                .clk      (clk),
                .cmd      (cmd),
                .pos      (cell_pos),
                .cmp_en   (accept),
                .new_val  (new_val),
                .prev_val (prev_v),
                .next_val (next_v),
                .entry    (entries[g]),
                .match    (match_vec[g])
            );

            assign hit_vec[g] = match_vec[g] && (CNT_W'(g) < count_reg);
        end
    endgenerate

    // Priority picks over the registered match flags.
    always_comb
    begin
        first_idx = '0;
        last_idx  = '0;
        for (int i = CAPACITY - 1; i >= 0; i--)
        begin
            if (hit_vec[i])
                first_idx = IDX_W'(i);
        end
        for (int i = 0; i < CAPACITY; i++)
        begin
            if (hit_vec[i])
                last_idx = IDX_W'(i);
        end
    end

    assign any_hit = |hit_vec;
    assign pos_c   = CMP_W'(pos_reg);
    assign cnt_c   = CMP_W'(count_reg);
    assign full    = (count_reg >= CAP_CNT);

    always_comb
    begin
        status_n   = STATUS_OK;
        found_n    = '1;
        count_next = count_reg;
        do_ins     = 1'b0;
        do_rem     = 1'b0;
        cell_pos   = pos_c;
        rd_idx     = IDX_W'(pos_c);

        if (clr_reg || (mode_reg == MODE_CLEAR))
        begin
            count_next = '0;
        end
        else
        begin
            case (mode_t'(mode_reg))
                MODE_APPEND:
                begin
                    cell_pos = cnt_c;
                    if (full)
                        status_n = STATUS_FULL;
                    else
                    begin
                        do_ins     = 1'b1;
                        count_next = count_reg + CNT_W'(1);
                    end
                end
                MODE_INSERT:
                begin
                    if (pos_c > cnt_c)
                        status_n = STATUS_RANGE;
                    else if (full)
                        status_n = STATUS_FULL;
                    else
                    begin
                        do_ins     = 1'b1;
                        count_next = count_reg + CNT_W'(1);
                    end
                end
                MODE_REMOVE_AT:
                begin
                    if (pos_c >= cnt_c)
                        status_n = STATUS_RANGE;
                    else
                    begin
                        do_rem     = 1'b1;
                        count_next = count_reg - CNT_W'(1);
                    end
                end
                MODE_REMOVE_VAL:
                begin
                    cell_pos = CMP_W'(first_idx);
                    if (!any_hit)
                        status_n = STATUS_NOT_FOUND;
                    else
                    begin
                        do_rem     = 1'b1;
                        count_next = count_reg - CNT_W'(1);
                    end
                end
                MODE_READ:
                begin
                    if (pos_c >= cnt_c)
                        status_n = STATUS_RANGE;
                end
                MODE_FIRST:
                begin
                    rd_idx = '0;
                    if (count_reg == '0)
                        status_n = STATUS_EMPTY;
                end
                MODE_LAST:
                begin
                    rd_idx = IDX_W'(count_reg - CNT_W'(1));
                    if (count_reg == '0)
                        status_n = STATUS_EMPTY;
                end
                MODE_FIND_FIRST:
                begin
                    if (any_hit)
                        found_n = POS_PORT_W'(first_idx);
                    else
                        status_n = STATUS_NOT_FOUND;
                end
                MODE_FIND_LAST:
                begin
                    if (any_hit)
                        found_n = POS_PORT_W'(last_idx);
                    else
                        status_n = STATUS_NOT_FOUND;
                end
                default:
                begin
                end
            endcase
        end
    end

    // Only read, first and last return data, and only on success.
    always_comb
    begin
        rd_n = '0;
        if (!clr_reg && (status_n == STATUS_OK) &&
            ((mode_reg == MODE_READ) || (mode_reg == MODE_FIRST) ||
             (mode_reg == MODE_LAST)))
            rd_n = entries[rd_idx];
    end

    assign cmd.ins = commit && do_ins;
    assign cmd.rem = commit && do_rem;

    // Control FSM
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        accept     = 1'b0;
        commit     = 1'b0;
        in_stall   = 1'b1;
        case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
                accept   = in_valid;
                if (in_valid)
                    state_next = ST_EXEC;
            end
            ST_EXEC:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    commit     = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (commit)
            out_valid_next = 1'b1;
        else if (!out_stall)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (commit)
                count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            mode_reg <= mode;
            pos_reg  <= position;
            val_reg  <= VALUE_WIDTH'(item_value);
            clr_reg  <= clear_all;
        end
        if (commit)
        begin
            status_reg     <= status_n;
            read_value_reg <= VALUE_PORT_W'(rd_n);
            found_reg      <= found_n;
            list_count_reg <= POS_PORT_W'(count_next);
        end
    end

    assign out_valid      = out_valid_reg;
    assign status         = status_reg;
    assign read_value     = read_value_reg;
    assign found_position = found_reg;
    assign list_count     = list_count_reg;

endmodule

`default_nettype wire

// ===== dv/tb_indexed_list_table_unit.sv =====
// Self-checking testbench for indexed_list_table_unit: directed list edits, then random traffic.
// Needs ilt_pkg and the indexed_list_table_unit RTL. A shadow list inside the bench
// predicts every result.

module tb_indexed_list_table_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import ilt_pkg::*;

    localparam int DEPTH = 64;
    localparam int POS_W = POS_PORT_W;
    localparam int VAL_W = VALUE_PORT_W;
    localparam logic signed [POS_W-1:0] NO_POSITION = -1;

    typedef struct packed {
        status_t                   status;
        logic [VAL_W-1:0]          read_value;
        logic signed [POS_W-1:0]   found;
        logic [POS_W-1:0]          count;
    } list_result_t;

    logic                        clk;
    logic                        rst_n;
    logic                        in_valid;
    logic                        in_stall;
    logic [3:0]                  mode;
    logic [POS_W-1:0]            position;
    logic [VAL_W-1:0]            item_value;
    logic                        clear_all;
    logic                        out_valid;
    logic                        out_stall;
    logic [2:0]                  status;
    logic [VAL_W-1:0]            read_value;
    logic signed [POS_W-1:0]     found_position;
    logic [POS_W-1:0]            list_count;

    // shadow copy of the list
    logic [VAL_W-1:0]            shadow_entries [DEPTH];
    int unsigned                 shadow_count;

    list_result_t                pending_results [$];
    int                          error_count;
    bit                          idling_on;

    logic [VAL_W-1:0]            value_pool [8] = '{
        32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0001, 32'h8000_0000,
        32'h5555_5555, 32'hAAAA_AAAA, 32'h1234_5678, 32'h7FFF_FFFF
    };

    indexed_list_table_unit dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .mode           (mode),
        .position       (position),
        .item_value     (item_value),
        .clear_all      (clear_all),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .status         (status),
        .read_value     (read_value),
        .found_position (found_position),
        .list_count     (list_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        #5_000_000;
        $display("tb_indexed_list_table_unit: errors");
        $finish;
    end

    task automatic flag_error(input string msg);
        $display("[%0t] %s", $time, msg);
        error_count++;
    endtask

    // first (or last) position holding v, -1 if none
    function automatic int locate_entry(input logic [VAL_W-1:0] v, input bit from_end);
        int hit;
        hit = -1;
        for (int i = 0; i < shadow_count; i++)
        begin
            if (shadow_entries[i] == v)
            begin
                hit = i;
                if (!from_end)
                    break;
            end
        end
        return hit;
    endfunction

    function automatic void drop_entry(input int unsigned pos);
        for (int unsigned i = pos; i + 1 < shadow_count; i++)
            shadow_entries[i] = shadow_entries[i + 1];
        shadow_count--;
    endfunction

    function automatic list_result_t predict_list_op(input logic [3:0] m,
                                                     input logic [POS_W-1:0] pos,
                                                     input logic [VAL_W-1:0] v,
                                                     input logic clr);
        list_result_t res;
        int hit;
        res.status     = STATUS_OK;
        res.read_value = '0;
        res.found      = NO_POSITION;
        if (clr || m == MODE_CLEAR)
            shadow_count = 0;
        else
        begin
            case (m)
                MODE_APPEND:
                begin
                    if (shadow_count >= DEPTH)
                        res.status = STATUS_FULL;
                    else
                    begin
                        shadow_entries[shadow_count] = v;
                        shadow_count++;
                    end
                end
                MODE_INSERT:
                begin
                    // range is checked ahead of fullness
                    if (pos > shadow_count)
                        res.status = STATUS_RANGE;
                    else if (shadow_count >= DEPTH)
                        res.status = STATUS_FULL;
                    else
                    begin
                        for (int unsigned i = shadow_count; i > pos; i--)
                            shadow_entries[i] = shadow_entries[i - 1];
                        shadow_entries[pos] = v;
                        shadow_count++;
                    end
                end
                MODE_REMOVE_AT:
                begin
                    if (pos >= shadow_count)
                        res.status = STATUS_RANGE;
                    else
                        drop_entry(pos);
                end
                MODE_REMOVE_VAL:
                begin
                    hit = locate_entry(v, 1'b0);
                    if (hit < 0)
                        res.status = STATUS_NOT_FOUND;
                    else
                        drop_entry(hit);
                end
                MODE_READ:
                begin
                    if (pos >= shadow_count)
                        res.status = STATUS_RANGE;
                    else
                        res.read_value = shadow_entries[pos];
                end
                MODE_FIRST, MODE_LAST:
                begin
                    if (shadow_count == 0)
                        res.status = STATUS_EMPTY;
                    else if (m == MODE_FIRST)
                        res.read_value = shadow_entries[0];
                    else
                        res.read_value = shadow_entries[shadow_count - 1];
                end
                MODE_FIND_FIRST, MODE_FIND_LAST:
                begin
                    hit = locate_entry(v, m == MODE_FIND_LAST);
                    if (hit < 0)
                        res.status = STATUS_NOT_FOUND;
                    else
                        res.found = hit[POS_W-1:0];
                end
                default:
                    ;
            endcase
        end
        res.count = shadow_count[POS_W-1:0];
        return res;
    endfunction

    // One request transaction: optional idle burst, then hold until accepted.
    task automatic send_request(input logic [3:0] m, input logic [POS_W-1:0] pos,
                                input logic [VAL_W-1:0] v, input logic clr);
        int gap;
        gap = 0;
        if (idling_on && $urandom_range(0, 4) == 0)
            gap = $urandom_range(1, 5);
        if (gap > 0)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        in_valid   <= 1'b1;
        mode       <= m;
        position   <= pos;
        item_value <= v;
        clear_all  <= clr;
        do
            @(posedge clk);
        while (in_stall);
        pending_results.push_back(predict_list_op(m, pos, v, clr));
    endtask

    task automatic wait_for_drain();
        // drop valid so the last transaction is not taken twice
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    // Receiver side: random stall bursts while idling is enabled.
    initial
    begin
        int burst;
        out_stall = 1'b0;
        burst = 0;
        forever
        begin
            @(negedge clk);
            if (burst == 0 && idling_on && $urandom_range(0, 5) == 0)
                burst = $urandom_range(1, 5);
            if (burst > 0)
            begin
                out_stall <= 1'b1;
                burst--;
            end
            else
                out_stall <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        list_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_results.size() == 0)
                flag_error($sformatf("result with nothing pending: status %0d count %0d",
                                     status, list_count));
            else
            begin
                want = pending_results.pop_front();
                if (status !== want.status)
                    flag_error($sformatf("status mismatch: got %0d want %0d",
                                         status, want.status));
                if (read_value !== want.read_value)
                    flag_error($sformatf("read_value mismatch: got %h want %h",
                                         read_value, want.read_value));
                if (found_position !== want.found)
                    flag_error($sformatf("found_position mismatch: got %0d want %0d",
                                         found_position, want.found));
                if (list_count !== want.count)
                    flag_error($sformatf("list_count mismatch: got %0d want %0d",
                                         list_count, want.count));
            end
        end
    end

    task automatic test_empty_list();
        send_request(MODE_FIRST,      0, 32'h0, 1'b0);
        send_request(MODE_LAST,       0, 32'h0, 1'b0);
        send_request(MODE_READ,       0, 32'h0, 1'b0);
        send_request(MODE_REMOVE_AT,  0, 32'h0, 1'b0);
        send_request(MODE_REMOVE_VAL, 0, 32'h0, 1'b0);
        send_request(MODE_FIND_FIRST, 0, 32'h0, 1'b0);
        send_request(MODE_FIND_LAST,  0, 32'hFFFF_FFFF, 1'b0);
        send_request(MODE_INSERT,     1, 32'h1, 1'b0);
        send_request(4'd10,           0, 32'h0, 1'b0);
    endtask

    task automatic test_edit_operations();
        send_request(MODE_APPEND,     0, 32'h0000_0000, 1'b0);
        send_request(MODE_APPEND,     0, 32'hFFFF_FFFF, 1'b0);
        send_request(MODE_INSERT,     0, 32'h5555_5555, 1'b0);
        send_request(MODE_INSERT,     3, 32'hFFFF_FFFF, 1'b0);
        send_request(MODE_INSERT,     2, 32'hAAAA_AAAA, 1'b0);
        send_request(MODE_INSERT,     6, 32'h1, 1'b0);
        send_request(MODE_READ,       0, 32'h0, 1'b0);
        send_request(MODE_READ,       4, 32'h0, 1'b0);
        send_request(MODE_READ,       5, 32'h0, 1'b0);
        send_request(MODE_READ,     127, 32'h0, 1'b0);
        send_request(MODE_FIRST,      0, 32'h0, 1'b0);
        send_request(MODE_LAST,       0, 32'h0, 1'b0);
        send_request(MODE_FIND_FIRST, 0, 32'hFFFF_FFFF, 1'b0);
        send_request(MODE_FIND_LAST,  0, 32'hFFFF_FFFF, 1'b0);
        send_request(MODE_FIND_FIRST, 0, 32'h1234_5678, 1'b0);
        send_request(MODE_REMOVE_VAL, 0, 32'hFFFF_FFFF, 1'b0);
        send_request(MODE_REMOVE_AT,  0, 32'h0, 1'b0);
        send_request(MODE_REMOVE_AT,  shadow_count[POS_W-1:0] - 1'b1, 32'h0, 1'b0);
        send_request(MODE_REMOVE_AT, 64, 32'h0, 1'b0);
        // clear_all wins over the mode
        send_request(MODE_APPEND,     0, 32'h7, 1'b1);
        send_request(MODE_APPEND,     0, 32'h1, 1'b0);
        send_request(MODE_CLEAR,      0, 32'h0, 1'b0);
        send_request(4'd15,         127, 32'hFFFF_FFFF, 1'b1);
    endtask

    task automatic test_full_store();
        send_request(MODE_CLEAR, 0, 32'h0, 1'b0);
        for (int k = 0; k < DEPTH; k++)
            send_request(MODE_APPEND, 0, k * 32'h9E37_79B9, 1'b0);
        send_request(MODE_APPEND,     0, 32'h1, 1'b0);
        send_request(MODE_INSERT,    64, 32'h1, 1'b0);
        send_request(MODE_INSERT,    65, 32'h1, 1'b0);
        send_request(MODE_INSERT,     0, 32'h1, 1'b0);
        send_request(MODE_READ,      63, 32'h0, 1'b0);
        send_request(MODE_LAST,       0, 32'h0, 1'b0);
        send_request(MODE_FIND_LAST,  0, 32'd63 * 32'h9E37_79B9, 1'b0);
        send_request(MODE_REMOVE_AT, 63, 32'h0, 1'b0);
        send_request(MODE_INSERT,    31, 32'hFFFF_FFFF, 1'b0);
        send_request(MODE_READ,      31, 32'h0, 1'b0);
    endtask

    task automatic test_random_traffic(input int n);
        logic [3:0]       m;
        logic [POS_W-1:0] pos;
        logic [VAL_W-1:0] v;
        logic             clr;
        int               r;
        int               trend;
        trend = 2;
        for (int k = 0; k < n; k++)
        begin
            // 0 grows the list toward full, 1 drains it, 2 is a mix that also sends clears
            if (k % 80 == 0)
                trend = $urandom_range(0, 2);
            r = $urandom_range(0, 99);
            case (trend)
                0:       m = (r < 55) ? MODE_APPEND : (r < 75) ? MODE_INSERT :
                             (r < 80) ? MODE_REMOVE_AT : (r < 83) ? MODE_REMOVE_VAL :
                             4'($urandom_range(MODE_READ, MODE_FIND_LAST));
                1:       m = (r < 10) ? MODE_APPEND : (r < 15) ? MODE_INSERT :
                             (r < 45) ? MODE_REMOVE_AT : (r < 65) ? MODE_REMOVE_VAL :
                             4'($urandom_range(MODE_READ, MODE_FIND_LAST));
                default: m = (r < 20) ? MODE_APPEND : (r < 35) ? MODE_INSERT :
                             (r < 47) ? MODE_REMOVE_AT : (r < 57) ? MODE_REMOVE_VAL :
                             (r < 95) ? 4'($urandom_range(MODE_READ, MODE_FIND_LAST)) :
                             (r < 97) ? MODE_CLEAR : 4'($urandom_range(10, 15));
            endcase
            r = $urandom_range(0, 9);
            if (r < 7)
                pos = POS_W'($urandom_range(0, shadow_count));
            else if (r == 7)
                pos = POS_W'($urandom_range(0, 127));
            else if (r == 8)
                pos = shadow_count[POS_W-1:0];
            else
                pos = (shadow_count == 0) ? '0 : POS_W'(shadow_count - 1);
            // mostly pooled values so finds and value removals hit
            if ($urandom_range(0, 9) < 7)
                v = value_pool[$urandom_range(0, 7)];
            else
                v = $urandom;
            clr = ($urandom_range(0, 199) == 0);
            send_request(m, pos, v, clr);
        end
    endtask

    task automatic test_drain_pause();
        test_random_traffic(50);
        wait_for_drain();
        test_random_traffic(100);
    endtask

    task automatic test_quiet_tail();
        idling_on = 1'b0;
        test_random_traffic(150);
    endtask

    initial
    begin
        int waited;
        error_count  = 0;
        shadow_count = 0;
        idling_on    = 1'b1;
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        mode         = '0;
        position     = '0;
        item_value   = '0;
        clear_all    = 1'b0;
        repeat (3) @(negedge clk);
        rst_n = 1'b1;

        test_empty_list();
        test_edit_operations();
        test_full_store();
        test_random_traffic(900);
        test_drain_pause();
        test_quiet_tail();

        @(negedge clk);
        in_valid <= 1'b0;
        waited = 0;
        while (pending_results.size() != 0 && waited < 5000)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (8) @(posedge clk);
        if (pending_results.size() != 0)
            flag_error($sformatf("%0d results never arrived", pending_results.size()));
        if (error_count == 0)
            $display("tb_indexed_list_table_unit: clean");
        else
            $display("tb_indexed_list_table_unit: errors");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/ilt_pkg.sv
rtl/ilt_cell.sv
rtl/indexed_list_table_unit.sv
dv/tb_indexed_list_table_unit.sv
